[hw/rtl/mcfe_pkg.sv]
// Shared constants, frame layout and CRC byte update for the drive command frame encoder.
package mcfe_pkg;

    localparam int ModeW  = 3;
    localparam int ByteW  = 8;
    localparam int IndexW = 4;
    localparam int CrcW   = 16;

    // Drive mode codes
    localparam logic [ModeW-1:0] MODE_FORWARD  = 3'd0;
    localparam logic [ModeW-1:0] MODE_BACKWARD = 3'd1;
    localparam logic [ModeW-1:0] MODE_LEFT     = 3'd2;
    localparam logic [ModeW-1:0] MODE_RIGHT    = 3'd3;

    // Frame byte positions
    localparam logic [IndexW-1:0] POS_HEADER = 4'd0;
    localparam logic [IndexW-1:0] POS_LENGTH = 4'd1;
    localparam logic [IndexW-1:0] POS_LEFT   = 4'd2;
    localparam logic [IndexW-1:0] POS_PAD0   = 4'd3;
    localparam logic [IndexW-1:0] POS_RIGHT  = 4'd4;
    localparam logic [IndexW-1:0] POS_PAD1   = 4'd5;
    localparam logic [IndexW-1:0] POS_FLAGS  = 4'd6;
    localparam logic [IndexW-1:0] POS_CRC_LO = 4'd7;
    localparam logic [IndexW-1:0] POS_CRC_HI = 4'd8;

    // Frame constants
    localparam logic [ByteW-1:0] FRAME_HEADER = 8'hFF;
    localparam logic [ByteW-1:0] FRAME_LENGTH = 8'd7;
    localparam logic [ByteW-1:0] FLAGS_FWD    = 8'd80;
    localparam logic [ByteW-1:0] FLAGS_BWD    = 8'd0;
    localparam logic [ByteW-1:0] FLAGS_LEFT   = 8'd64;
    localparam logic [ByteW-1:0] FLAGS_STOP   = 8'd16;

    localparam logic [CrcW-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CrcW-1:0] CRC_POLY = 16'hA001;

    // One byte of reflected CRC-16: eight shift-and-xor steps
    function automatic logic [CrcW-1:0] crc_update(input logic [CrcW-1:0] crc_in,
                                                   input logic [ByteW-1:0] data);
        logic [CrcW-1:0] c;
        c = crc_in ^ {{(CrcW-ByteW){1'b0}}, data};
        for (int i = 0; i < ByteW; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/motor_command_frame_encoder_top.sv]
// Drive command frame encoder: one command in, nine frame bytes out with CRC-16.
//
//  channel | signals                              | beat carries
//  --------+--------------------------------------+-------------------------------
//  in      | in_valid, in_ready, mode, speed      | one drive command
//  out     | out_valid, out_ready, frame_byte,    | one frame byte, its position,
//          | byte_index, last                     | and end-of-frame mark
//
// Each command yields nine output beats, so the byte-wide output channel bounds
// the command rate.
// A one-entry input register takes the next command while the current frame is
// still draining, so frames leave back to back with no gap between them.
// The CRC is folded in one byte per output beat as bytes 1 to 6 go out, and is
// complete when the CRC low byte is due.
// Reset clears the valid flags and the byte position; payload holds no reset.
// A stall on out_ready holds the current byte; a full input register drops in_ready unless it loads the serializer.
module motor_command_frame_encoder_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mcfe_pkg::ModeW-1:0]   mode,
    input  logic [mcfe_pkg::ByteW-1:0]   speed,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mcfe_pkg::ByteW-1:0]   frame_byte,
    output logic [mcfe_pkg::IndexW-1:0]  byte_index,
    output logic                         last
);
    import mcfe_pkg::*;

    // input holding register
    logic              cmd_valid_reg, cmd_valid_next;
    logic [ModeW-1:0]  mode_reg;
    logic [ByteW-1:0]  speed_reg;

    // frame serializer
    logic              ser_valid_reg, ser_valid_next;
    logic [IndexW-1:0] idx_reg, idx_next;
    logic [ByteW-1:0]  lft_reg, lft_next;
    logic [ByteW-1:0]  rgt_reg, rgt_next;
    logic [ByteW-1:0]  flags_reg, flags_next;
    logic [CrcW-1:0]   crc_reg, crc_next;

    logic              in_beat;
    logic              out_beat;
    logic              frame_done;
    logic              load;
    logic [ByteW-1:0]  cur_byte;
    logic [ByteW-1:0]  dec_lft, dec_rgt, dec_flags;

    assign out_beat   = ser_valid_reg && out_ready;
    assign frame_done = out_beat && (idx_reg == POS_CRC_HI);
    // move the held command into the serializer when it is free or finishing
    assign load       = cmd_valid_reg && (!ser_valid_reg || frame_done);
    assign in_ready   = !cmd_valid_reg || load;
    assign in_beat    = in_valid && in_ready;

    // Mode decode; unknown codes fall to stop, which ignores speed
    always_comb
    begin
        dec_lft   = '0;
        dec_rgt   = '0;
        dec_flags = FLAGS_STOP;
        unique case (mode_reg)
            MODE_FORWARD:
            begin
                dec_lft   = speed_reg;
                dec_rgt   = speed_reg;
                dec_flags = FLAGS_FWD;
            end
            MODE_BACKWARD:
            begin
                dec_lft   = speed_reg;
                dec_rgt   = speed_reg;
                dec_flags = FLAGS_BWD;
            end
            MODE_LEFT:
            begin
                dec_rgt   = speed_reg;
                dec_flags = FLAGS_LEFT;
            end
            MODE_RIGHT:
            begin
                dec_lft   = speed_reg;
                dec_flags = FLAGS_STOP;
            end
            default:
            begin
                dec_lft   = '0;
                dec_rgt   = '0;
                dec_flags = FLAGS_STOP;
            end
        endcase
    end

    // Select the byte at the current position
    always_comb
    begin
        case (idx_reg)
            POS_HEADER: cur_byte = FRAME_HEADER;
            POS_LENGTH: cur_byte = FRAME_LENGTH;
            POS_LEFT:   cur_byte = lft_reg;
            POS_PAD0:   cur_byte = '0;
            POS_RIGHT:  cur_byte = rgt_reg;
            POS_PAD1:   cur_byte = '0;
            POS_FLAGS:  cur_byte = flags_reg;
            POS_CRC_LO: cur_byte = crc_reg[ByteW-1:0];
            POS_CRC_HI: cur_byte = crc_reg[CrcW-1:ByteW];
            default:    cur_byte = '0;
        endcase
    end

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        ser_valid_next = ser_valid_reg;
        idx_next       = idx_reg;
        lft_next       = lft_reg;
        rgt_next       = rgt_reg;
        flags_next     = flags_reg;
        crc_next       = crc_reg;

        if (load)
        begin
            cmd_valid_next = 1'b0;
        end
        if (in_beat)
        begin
            cmd_valid_next = 1'b1;
        end

        if (load)
        begin
            ser_valid_next = 1'b1;
            idx_next       = POS_HEADER;
            lft_next       = dec_lft;
            rgt_next       = dec_rgt;
            flags_next     = dec_flags;
            crc_next       = CRC_INIT;
        end
        else if (frame_done)
        begin
            ser_valid_next = 1'b0;
        end
        else if (out_beat)
        begin
            idx_next = idx_reg + 1'b1;
            // fold bytes 1 to 6 into the CRC as they leave
            if (idx_reg >= POS_LENGTH && idx_reg <= POS_FLAGS)
            begin
                crc_next = crc_update(crc_reg, cur_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            ser_valid_reg <= 1'b0;
            idx_reg       <= POS_HEADER;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            ser_valid_reg <= ser_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            mode_reg  <= mode;
            speed_reg <= speed;
        end
        lft_reg   <= lft_next;
        rgt_reg   <= rgt_next;
        flags_reg <= flags_next;
        crc_reg   <= crc_next;
    end

    assign out_valid  = ser_valid_reg;
    assign frame_byte = cur_byte;
    assign byte_index = idx_reg;
    assign last       = (idx_reg == POS_CRC_HI);

endmodule
